@@ rtl/afwd_pkg.sv @@
// ----------------------------------------------------------------------------
// afwd_pkg
// Shared types and constants for the ARP flood window detector.
// ----------------------------------------------------------------------------
package afwd_pkg;

    localparam int KEY_W   = 48;
    localparam int CNT_W   = 8;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 8;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_WINDOW_COUNT  = 2'd0;
    localparam logic [IDX_W-1:0] REG_REQ_SPAN      = 2'd1;
    localparam logic [IDX_W-1:0] REG_REPLY_SPAN    = 2'd2;
    localparam logic [IDX_W-1:0] REG_REPORT_IVL    = 2'd3;

    localparam logic [CFG_W-1:0] RST_WINDOW_COUNT  = 8'd100;
    localparam logic [CFG_W-1:0] RST_SPAN          = 8'd1;
    localparam logic [CFG_W-1:0] RST_REPORT_IVL    = 8'd20;

    typedef enum logic [1:0] {
        VERDICT_COUNTED = 2'd0,
        VERDICT_BLACK   = 2'd1,
        VERDICT_CLEAN   = 2'd2,
        VERDICT_ATTACK  = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [1:0]       verdict;
        logic [KEY_W-1:0] offender;
        logic             hit_report;
        logic             blacklist_full;
    } result_t;

endpackage

@@ rtl/arp_flood_window_detector.sv @@
// ----------------------------------------------------------------------------
// arp_flood_window_detector
// Per-kind sender windows, max-count detection and blacklists for ARP.
// ----------------------------------------------------------------------------
// One request at a time. A request scans its kind's blacklist and then its
// sender table. Each scan step is one read of the memory, then one compare.
// The blacklist scan covers up to BLACKLIST_DEPTH entries and the table scan
// up to the distinct count. A request for a new sender runs both scans to the
// end; a request that ends on a blacklist or table match stops its scan there.
// A clean window close adds a wipe of the counts.
// An attack close adds a maximum scan (one read and one compare per entry),
// a key fetch, and then the wipe.
// The input stays blocked while a result waits for m_ready.
// After reset, a clearing pass over TABLE_DEPTH entries zeroes the count
// tables before the first request.
// ----------------------------------------------------------------------------
module arp_flood_window_detector #(
    parameter int TABLE_DEPTH     = 128,
    parameter int BLACKLIST_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [31:0] s_sender_ip,
    input  logic [47:0] s_sender_mac,
    input  logic [31:0] s_time_sec,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_verdict,
    output logic [47:0] m_offender,
    output logic        m_hit_report,
    output logic        m_blacklist_full,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    localparam int TA_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TC_W = $clog2(TABLE_DEPTH + 1);
    localparam int BA_W = (BLACKLIST_DEPTH > 1) ? $clog2(BLACKLIST_DEPTH) : 1;
    localparam int BC_W = $clog2(BLACKLIST_DEPTH + 1);
    localparam int IX_W = (TC_W > BC_W) ? TC_W : BC_W;
    localparam int TOP  = (TABLE_DEPTH < 255) ? TABLE_DEPTH : 255;
    localparam int KW   = afwd_pkg::KEY_W;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_BL_RD, ST_BL_CMP, ST_TB_RD, ST_TB_CMP, ST_TB_WR,
        ST_MX_RD, ST_MX_CMP, ST_KEY_RD, ST_KEY_GET, ST_WIPE, ST_OUT
    } state_t;

    state_t state_reg;

    logic [7:0] win_cnt_reg, req_span_reg, rep_span_reg, rpt_ivl_reg;

    // memories, indexed {kind, addr}
    logic [KW-1:0]              tkey_mem [2 << TA_W];
    logic [afwd_pkg::CNT_W-1:0] tcnt_mem [2 << TA_W];
    logic [KW-1:0]              bl_mem   [2 << BA_W];
    logic [KW-1:0]              tkey_rd_reg, bl_rd_reg;
    logic [afwd_pkg::CNT_W-1:0] tcnt_rd_reg;

    logic [TC_W-1:0] distinct_reg [2];
    logic [7:0]      packets_reg  [2];
    logic [31:0]     first_reg    [2];
    logic [BC_W-1:0] used_reg     [2];
    logic [7:0]      phase_reg    [2];

    logic            kind_reg;
    logic [KW-1:0]   key_reg;
    logic [31:0]     now_reg;
    logic [IX_W-1:0] idx_reg;
    logic [TA_W-1:0] best_reg;
    logic [7:0]      best_cnt_reg;
    logic [7:0]      pk_reg;
    logic            found_reg;
    afwd_pkg::result_t res_reg;
    logic            m_valid_reg;

    logic [7:0] win_len;
    always_comb begin
        if (win_cnt_reg < 8'd2) win_len = 8'd2;
        else if (32'(win_cnt_reg) > TOP) win_len = 8'(TOP);
        else win_len = win_cnt_reg;
    end

    logic [7:0] ivl;
    assign ivl = (rpt_ivl_reg == 8'd0) ? 8'd1 : rpt_ivl_reg;

    logic [31:0] span;
    assign span = now_reg - first_reg[kind_reg];
    logic [7:0] lim;
    assign lim = kind_reg ? rep_span_reg : req_span_reg;

    logic [TA_W-1:0] taddr;
    assign taddr = idx_reg[TA_W-1:0];
    logic [7:0] ph_inc;
    assign ph_inc = phase_reg[kind_reg] + 8'd1;

    assign s_ready   = (state_reg == ST_IDLE) && !m_valid_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            win_cnt_reg <= afwd_pkg::RST_WINDOW_COUNT;
            req_span_reg <= afwd_pkg::RST_SPAN;
            rep_span_reg <= afwd_pkg::RST_SPAN;
            rpt_ivl_reg <= afwd_pkg::RST_REPORT_IVL;
            for (int k = 0; k < 2; k++) begin
                distinct_reg[k] <= '0;
                packets_reg[k]  <= '0;
                first_reg[k]    <= '0;
                used_reg[k]     <= '0;
                phase_reg[k]    <= '0;
            end
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    afwd_pkg::REG_WINDOW_COUNT: win_cnt_reg  <= cfg_data;
                    afwd_pkg::REG_REQ_SPAN:     req_span_reg <= cfg_data;
                    afwd_pkg::REG_REPLY_SPAN:   rep_span_reg <= cfg_data;
                    afwd_pkg::REG_REPORT_IVL:   rpt_ivl_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR: begin
                    tcnt_mem[{1'b0, taddr}] <= '0;
                    tcnt_mem[{1'b1, taddr}] <= '0;
                    if (idx_reg == IX_W'(TABLE_DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        kind_reg <= s_kind;
                        key_reg  <= s_kind ? s_sender_mac : {16'd0, s_sender_ip};
                        now_reg  <= s_time_sec;
                        idx_reg  <= '0;
                        res_reg  <= '0;
                        state_reg <= ST_BL_RD;
                    end
                end
                ST_BL_RD: begin
                    if (idx_reg >= IX_W'(used_reg[kind_reg])
                            || idx_reg >= IX_W'(BLACKLIST_DEPTH)) begin
                        pk_reg <= packets_reg[kind_reg] + 8'd1;
                        if (packets_reg[kind_reg] == 8'd0) first_reg[kind_reg] <= now_reg;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        state_reg <= ST_TB_RD;
                    end else begin
                        bl_rd_reg <= bl_mem[{kind_reg, idx_reg[BA_W-1:0]}];
                        state_reg <= ST_BL_CMP;
                    end
                end
                ST_BL_CMP: begin
                    if (bl_rd_reg == key_reg) begin
                        res_reg.verdict  <= afwd_pkg::VERDICT_BLACK;
                        res_reg.offender <= key_reg;
                        if (ph_inc >= ivl) begin
                            res_reg.hit_report <= 1'b1;
                            phase_reg[kind_reg] <= '0;
                        end else begin
                            phase_reg[kind_reg] <= ph_inc;
                        end
                        state_reg <= ST_OUT;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_BL_RD;
                    end
                end
                ST_TB_RD: begin
                    if (idx_reg >= IX_W'(distinct_reg[kind_reg])) begin
                        state_reg <= ST_TB_WR;
                    end else begin
                        tkey_rd_reg <= tkey_mem[{kind_reg, taddr}];
                        tcnt_rd_reg <= tcnt_mem[{kind_reg, taddr}];
                        state_reg <= ST_TB_CMP;
                    end
                end
                ST_TB_CMP: begin
                    if (tkey_rd_reg == key_reg) begin
                        found_reg <= 1'b1;
                        state_reg <= ST_TB_WR;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_TB_RD;
                    end
                end
                ST_TB_WR: begin
                    packets_reg[kind_reg] <= pk_reg;
                    if (found_reg) begin
                        if (tcnt_rd_reg != 8'd255)
                            tcnt_mem[{kind_reg, taddr}] <= tcnt_rd_reg + 8'd1;
                    end else if (distinct_reg[kind_reg] < TC_W'(TABLE_DEPTH)) begin
                        tkey_mem[{kind_reg, taddr}] <= key_reg;
                        tcnt_mem[{kind_reg, taddr}] <= 8'd1;
                        distinct_reg[kind_reg] <= distinct_reg[kind_reg] + 1'b1;
                    end
                    idx_reg      <= '0;
                    best_reg     <= '0;
                    best_cnt_reg <= '0;
                    if (pk_reg < win_len) begin
                        state_reg <= ST_OUT;
                    end else if (span <= 32'(lim)) begin
                        state_reg <= ST_MX_RD;
                    end else begin
                        res_reg.verdict <= afwd_pkg::VERDICT_CLEAN;
                        state_reg <= ST_WIPE;
                    end
                end
                ST_MX_RD: begin
                    if (idx_reg >= IX_W'(distinct_reg[kind_reg])) begin
                        state_reg <= ST_KEY_RD;
                    end else begin
                        tcnt_rd_reg <= tcnt_mem[{kind_reg, taddr}];
                        state_reg <= ST_MX_CMP;
                    end
                end
                ST_MX_CMP: begin
                    if (tcnt_rd_reg > best_cnt_reg) begin
                        best_cnt_reg <= tcnt_rd_reg;
                        best_reg     <= taddr;
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= ST_MX_RD;
                end
                ST_KEY_RD: begin
                    tkey_rd_reg <= tkey_mem[{kind_reg, best_reg}];
                    state_reg <= ST_KEY_GET;
                end
                ST_KEY_GET: begin
                    res_reg.verdict  <= afwd_pkg::VERDICT_ATTACK;
                    res_reg.offender <= tkey_rd_reg;
                    if (used_reg[kind_reg] < BC_W'(BLACKLIST_DEPTH)) begin
                        bl_mem[{kind_reg, used_reg[kind_reg][BA_W-1:0]}] <= tkey_rd_reg;
                        used_reg[kind_reg] <= used_reg[kind_reg] + 1'b1;
                    end else begin
                        res_reg.blacklist_full <= 1'b1;
                    end
                    idx_reg   <= '0;
                    state_reg <= ST_WIPE;
                end
                ST_WIPE: begin
                    if (idx_reg >= IX_W'(distinct_reg[kind_reg])) begin
                        distinct_reg[kind_reg] <= '0;
                        packets_reg[kind_reg]  <= '0;
                        first_reg[kind_reg]    <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        tcnt_mem[{kind_reg, taddr}] <= '0;
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_OUT: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_verdict        = res_reg.verdict;
    assign m_offender       = res_reg.offender;
    assign m_hit_report     = res_reg.hit_report;
    assign m_blacklist_full = res_reg.blacklist_full;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("accept while busy");
    a_report_only_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_hit_report) |-> (m_verdict == afwd_pkg::VERDICT_BLACK))
        else $error("hit report without blacklist verdict");
    a_full_only_attack: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_blacklist_full) |-> (m_verdict == afwd_pkg::VERDICT_ATTACK))
        else $error("full flag without attack verdict");
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (used_reg[0] <= BC_W'(BLACKLIST_DEPTH)) && (used_reg[1] <= BC_W'(BLACKLIST_DEPTH)))
        else $error("blacklist overflow");
endmodule
